// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cdq_pkg.sv =====
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 8;
  localparam int OCC_W     = 4;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN,
    CMD_SHIFT_OUT,
    CMD_APPEND,
    CMD_TRIM
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

endpackage

// ===== design/circular_deque.sv =====
`timescale 1ns / 1ps

// Double-ended queue of bytes holding up to DEPTH-1 words.
// The input channel (in_valid, in_ready, op, value) takes one operation per
// word: push front, push rear, pop front or pop rear. The output channel
// (out_valid, out_ready, popped, status, front_item, rear_item, is_empty,
// is_full, occupancy) returns one result word per input word, in order.
// The words sit in a row of cells with the front word in the first cell;
// pushes and pops at the front shift the whole row, rear operations change
// only the cell at the end of the filled part.
// The rear word reaches the first cell through a registered ripple of one
// cell per cycle, so a result is loaded only once a busy counter, set to N,
// the number of words held after the operation, has run down to zero. A new
// input is taken in the cycle after the result is loaded.
// A result waits in the output register while out_ready is low; the next
// input may be taken meanwhile, and its result is held back until the
// output register is free.
// Reset empties the deque and drops any pending result.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [cdq_pkg::DATA_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cdq_pkg::DATA_W-1:0] popped,
  output logic [1:0]                 status,
  output logic [cdq_pkg::DATA_W-1:0] front_item,
  output logic [cdq_pkg::DATA_W-1:0] rear_item,
  output logic                       is_empty,
  output logic                       is_full,
  output logic [cdq_pkg::OCC_W-1:0]  occupancy
);
  import cdq_pkg::*;

  localparam int NC = DEPTH - 1;
  localparam int CW = $clog2(DEPTH);

  logic [DATA_W-1:0] cell_data  [NC];
  logic              cell_valid [NC];
  logic [DATA_W-1:0] cell_rr    [NC];

  cell_cmd_t         cmd;
  cmd_kind_t         kind;
  status_t           st;
  logic [DATA_W-1:0] pop_val;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     cnt, cnt_next;
  state_t            state, state_next;
  logic              accept, deliver, full, empty;
  status_t           pend_status;
  logic [DATA_W-1:0] pend_popped;

  assign accept = in_valid && in_ready;
  assign full   = (count == CW'(NC));
  assign empty  = (count == '0);

  always_comb begin
    kind       = CMD_HOLD;
    st         = ST_DONE;
    pop_val    = '0;
    count_next = count;
    case (op_t'(op))
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          kind       = CMD_SHIFT_IN;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          kind       = CMD_APPEND;
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          kind       = CMD_SHIFT_OUT;
          pop_val    = cell_data[0];
          count_next = count - CW'(1);
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          kind       = CMD_TRIM;
          pop_val    = cell_rr[0];
          count_next = count - CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign cmd.kind  = accept ? kind : CMD_HOLD;
  assign cmd.value = value;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic [DATA_W-1:0] l_data, r_data, r_rr;
    logic              l_valid, r_valid;

    if (i == 0) begin : g_first
      assign l_data  = value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == NC - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
      assign r_rr    = '0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
      assign r_rr    = cell_rr[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .right_rr    (r_rr),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .rr          (cell_rr[i])
    );
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    deliver    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_BUSY;
          cnt_next   = count_next;
        end
      end
      S_BUSY: begin
        if (cnt != '0) begin
          cnt_next = cnt - CW'(1);
        end else if (!out_valid || out_ready) begin
          deliver    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) count <= count_next;
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st;
      pend_popped <= pop_val;
    end
    if (deliver) begin
      popped     <= pend_popped;
      status     <= pend_status;
      front_item <= empty ? '0 : cell_data[0];
      rear_item  <= empty ? '0 : cell_rr[0];
      is_empty   <= empty;
      is_full    <= full;
      occupancy  <= OCC_W'(count);
    end
  end

endmodule

// ===== design/cdq_cell.sv =====
`timescale 1ns / 1ps

module cdq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  cdq_pkg::cell_cmd_t        cmd,
  input  logic [cdq_pkg::DATA_W-1:0] left_data,
  input  logic                      left_valid,
  input  logic [cdq_pkg::DATA_W-1:0] right_data,
  input  logic                      right_valid,
  input  logic [cdq_pkg::DATA_W-1:0] right_rr,
  output logic [cdq_pkg::DATA_W-1:0] data,
  output logic                      valid,
  output logic [cdq_pkg::DATA_W-1:0] rr
);
  import cdq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.kind)
        CMD_SHIFT_IN:  valid <= left_valid;
        CMD_SHIFT_OUT: valid <= right_valid;
        CMD_APPEND: begin
          if (!valid && left_valid) valid <= 1'b1;
        end
        CMD_TRIM: begin
          if (valid && !right_valid) valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.kind)
      CMD_SHIFT_IN:  data <= left_data;
      CMD_SHIFT_OUT: data <= right_data;
      CMD_APPEND: begin
        if (!valid && left_valid) data <= cmd.value;
      end
      default: ;
    endcase
  end

  // The rear item ripples toward the front one cell per cycle.
  always_ff @(posedge clk) begin
    rr <= right_valid ? right_rr : data;
  end

endmodule

// ===== design/cdq_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cdq_pkg::DATA_W-1:0] popped,
  input logic [1:0]                 status,
  input logic [cdq_pkg::DATA_W-1:0] front_item,
  input logic [cdq_pkg::DATA_W-1:0] rear_item,
  input logic                       is_empty,
  input logic                       is_full,
  input logic [cdq_pkg::OCC_W-1:0]  occupancy
);
  import cdq_pkg::*;

  `CDQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(popped) && $stable(status), "result word changed while stalled")
  `CDQ_ASSERT(a_empty_zero, out_valid && is_empty |-> front_item == '0 && rear_item == '0 && occupancy == '0, "empty deque reports items")
  `CDQ_ASSERT(a_not_both, out_valid |-> !(is_empty && is_full), "deque reported empty and full")
  `CDQ_ASSERT(a_refused_zero, out_valid && status != ST_DONE |-> popped == '0, "refused operation returned a word")
  `CDQ_ASSERT(a_one_at_time, in_valid && in_ready |=> !in_ready, "second word taken while busy")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
